@@ src/wbps_pkg.sv @@
package wbps_pkg;

  // window and pattern geometry
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int PAT_BYTES         = 16;
  localparam int PAT_IDX_W         = $clog2(PAT_BYTES);
  localparam int LEN_LIMIT         = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES
                                                                     : PAT_BYTES;
  localparam int LEN_W             = 5;
  localparam int WILD_W            = 16;

  // region counting
  localparam longint MAX_REGION_BYTES = 64'd16777216;
  localparam int     CNT_W            = $clog2(MAX_REGION_BYTES) + 1;
  localparam int     OFF_W            = 24;
  localparam logic [CNT_W-1:0] REGION_MAX = CNT_W'(MAX_REGION_BYTES);

  // configuration port
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_WILD   = 2'd2,
    REG_LEN    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] pat_lo;
    logic [DATA_W-1:0] pat_hi;
    logic [WILD_W-1:0] wild;
    logic [LEN_W-1:0]  len;
  } cfg_t;

  typedef struct packed {
    logic       care;
    logic [7:0] pat;
  } cell_cfg_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } res_t;

endpackage

@@ src/wbps_regs.sv @@
module wbps_regs
  import wbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pat_lo <= '0;
      cfg.pat_hi <= '0;
      cfg.wild   <= '0;
      cfg.len    <= LEN_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_PAT_LO: cfg.pat_lo <= pwdata;
        REG_PAT_HI: cfg.pat_hi <= pwdata;
        REG_WILD:   cfg.wild   <= pwdata[WILD_W-1:0];
        REG_LEN:    cfg.len    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAT_LO: prdata = cfg.pat_lo;
      REG_PAT_HI: prdata = cfg.pat_hi;
      REG_WILD:   prdata = DATA_W'(cfg.wild);
      REG_LEN:    prdata = DATA_W'(cfg.len);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ src/wbps_cell.sv @@
module wbps_cell
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] din,
  input  cell_cfg_t  ccfg,
  output logic [7:0] dout,
  output logic       hit
);

  logic [7:0] q;

  // byte moves one place down the window on every accepted request
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= din;
    end
  end

  assign dout = q;
  // compare the byte this cell is about to hold
  assign hit  = !ccfg.care || (din == ccfg.pat);

endmodule

@@ src/wbps_out.sv @@
module wbps_out
  import wbps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  input  logic out_stall,
  output logic out_valid,
  output res_t out_res,
  output logic full
);

  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= push;
        if (push) begin
          skid_res <= push_res;
        end
      end else begin
        out_valid <= push;
        if (push) begin
          out_res <= push_res;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_res   <= push_res;
    end
  end

endmodule

@@ src/wildcard_byte_pattern_scanner.sv @@
// Wildcard byte pattern scanner. Region bytes arrive one request per clock on data_byte
// while in_stall is low, with region_end set on the final byte. A row of byte cells shifts
// the region through a 16-byte window, and each cell compares the byte it takes in against
// the pattern byte that lines up with it (or ignores it if that byte is a wildcard or lies
// beyond pattern_length). The first complete match in a region yields one result with
// match_found set and match_offset the offset of its first byte; a region with no match
// yields one result with match_found clear on its final byte. Later matches in the same
// region are ignored, and every region starts fresh after its final byte. The block takes
// one byte every cycle while in_stall is low: the compare of all cells and the offset
// subtract sit between the input and the result register. in_stall rises only when a
// result sits in the output register and a second one fills the skid stage behind it while
// out_stall holds. The 64-bit configuration port has registers at byte addresses 0, 8, 16
// and 24 (pattern bytes 0-7, pattern bytes 8-15, wildcard mask, pattern length); a length
// of 0 acts as 1 and one above 16 acts as 16. Offsets saturate at 2^24 minus the pattern
// length for very long regions.
module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // byte requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              region_end,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic              match_found,
  output logic [OFF_W-1:0]  match_offset
);

  cfg_t cfg;

  wbps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clamp the length into 1..LEN_LIMIT
  logic [LEN_W-1:0] len;
  always_comb begin
    if (cfg.len == '0) begin
      len = LEN_W'(1);
    end else if (cfg.len > LEN_W'(LEN_LIMIT)) begin
      len = LEN_W'(LEN_LIMIT);
    end else begin
      len = cfg.len;
    end
  end

  // pattern bytes as a table indexed by pattern position
  logic [7:0] pat_byte [PAT_BYTES];
  for (genvar p = 0; p < PAT_BYTES; p++) begin : g_pat
    if (p < 8) begin : g_lo
      assign pat_byte[p] = cfg.pat_lo[8*p +: 8];
    end else begin : g_hi
      assign pat_byte[p] = cfg.pat_hi[8*(p-8) +: 8];
    end
  end

  logic in_fire;
  assign in_fire = in_valid && !in_stall;

  // cell row: cell 0 takes the new byte, cell j holds the byte j places back
  logic [7:0] cell_din  [MAX_PATTERN_BYTES];
  logic [7:0] cell_dout [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_hit;
  cell_cfg_t  cell_cfg  [MAX_PATTERN_BYTES];

  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_din[j] = data_byte;
    end else begin : g_link
      assign cell_din[j] = cell_dout[j-1];
    end

    if (j < LEN_LIMIT) begin : g_used
      // pattern byte len-1-j lines up with window position j
      logic [LEN_W-1:0] k;
      assign k = len - LEN_W'(1) - LEN_W'(j);
      assign cell_cfg[j].care = (LEN_W'(j) < len) && !cfg.wild[k[PAT_IDX_W-1:0]];
      assign cell_cfg[j].pat  = pat_byte[k[PAT_IDX_W-1:0]];
    end else begin : g_spare
      assign cell_cfg[j].care = 1'b0;
      assign cell_cfg[j].pat  = '0;
    end

    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .din      (cell_din[j]),
      .ccfg     (cell_cfg[j]),
      .dout     (cell_dout[j]),
      .hit      (cell_hit[j])
    );
  end

  // region bookkeeping
  logic [CNT_W-1:0] bytes_seen;
  logic [CNT_W-1:0] bytes_seen_next;
  logic             already_found;
  logic             match;
  logic [CNT_W-1:0] start_pos;
  logic             push;
  res_t             push_res;

  assign bytes_seen_next = (bytes_seen == REGION_MAX) ? bytes_seen
                                                      : bytes_seen + CNT_W'(1);
  assign start_pos       = bytes_seen_next - CNT_W'(len);
  // no earlier match in the region, enough bytes in the window and every cell agrees
  assign match           = !already_found && (bytes_seen_next >= CNT_W'(len)) && (&cell_hit);
  assign push            = in_fire && (match || (region_end && !already_found));
  assign push_res.found  = match;
  assign push_res.offset = match ? start_pos[OFF_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      already_found <= 1'b0;
    end else if (in_fire) begin
      if (region_end) begin
        bytes_seen    <= '0;
        already_found <= 1'b0;
      end else begin
        bytes_seen    <= bytes_seen_next;
        already_found <= already_found || match;
      end
    end
  end

  // result register with skid stage behind it
  res_t out_res;
  logic out_full;

  wbps_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (out_full)
  );

  assign in_stall     = out_full;
  assign match_found  = out_res.found;
  assign match_offset = out_res.offset;

endmodule

@@ src/wbps_checker.sv @@
module wbps_checker
  import wbps_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             match_found,
  input logic [OFF_W-1:0] match_offset
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(match_found) && $stable(match_offset))
    else $error("result changed while stalled");

  // not-found results carry a zero offset
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> match_offset == '0)
    else $error("not-found result with nonzero offset");

  // skid stage only fills behind a full output register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output backpressure");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("handshake not idle after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .match_found  (match_found),
  .match_offset (match_offset)
);
